>>> hdl/cdma_pkg.sv
// Shared types and constants of the counter delta moving average unit.
package cdma_pkg;

  // Width of one absolute sector counter.
  localparam int unsigned CNT_W = 32;
  // Width of one halved delta (kilobytes).
  localparam int unsigned DELTA_W = CNT_W - 1;
  // Width of the window length register.
  localparam int unsigned WIN_W = 5;
  // Largest window the register can express.
  localparam int unsigned WIN_MAX = (1 << WIN_W) - 1;
  // Width of a per-direction window sum: WIN_MAX deltas of DELTA_W bits.
  localparam int unsigned SUM_W = DELTA_W + WIN_W;
  // Q8 fraction bits of the averages.
  localparam int unsigned FRAC_W = 8;
  // Divider lane width: total sum (SUM_W + 1) shifted by FRAC_W, made even.
  localparam int unsigned DVD_W = ((SUM_W + 1 + FRAC_W + 1) / 2) * 2;
  // Quotient bits resolved per divider cycle.
  localparam int unsigned DIV_RADIX_BITS = 2;
  // Divider steps per division.
  localparam int unsigned DIV_STEPS = DVD_W / DIV_RADIX_BITS;

  // Output field widths.
  localparam int unsigned AVG_TOTAL_W = 40;
  localparam int unsigned AVG_DIR_W = 39;

  // One history slot; the total slot is always rd + wr and is not stored.
  typedef struct packed {
    logic [DELTA_W-1:0] wr;
    logic [DELTA_W-1:0] rd;
  } hist_entry_t;

  localparam int unsigned ENTRY_W = $bits(hist_entry_t);

  // Three divider lanes: dividends going in, quotients coming out.
  typedef struct packed {
    logic [DVD_W-1:0] total;
    logic [DVD_W-1:0] rd;
    logic [DVD_W-1:0] wr;
  } div_lanes_t;

endpackage

>>> hdl/cdma_hist_ram.sv
// History memory: one write and one registered read port, entries read zero until written.
module cdma_hist_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  cdma_pkg::hist_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output cdma_pkg::hist_entry_t rdata_o
);

  cdma_pkg::hist_entry_t mem [DEPTH];
  cdma_pkg::hist_entry_t rdata_q;
  logic [DEPTH-1:0]      valid_q;
  logic                  rvld_q;

  // Storage array and read data register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Written-entry flags, cleared at reset so history starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= valid_q[raddr_i];
      end
    end
  end

  // Mask entries never written
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> hdl/cdma_div3.sv
// Three-lane radix-4 restoring divider by a small shared divisor.
module cdma_div3 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [cdma_pkg::WIN_W-1:0]        divisor_i,
  input  cdma_pkg::div_lanes_t              dividend_i,
  output logic                              done_o,
  output cdma_pkg::div_lanes_t              quot_o
);

  localparam int unsigned DW = cdma_pkg::DVD_W;
  localparam int unsigned RW = cdma_pkg::WIN_W;
  localparam int unsigned CW = $clog2(cdma_pkg::DIV_STEPS + 1);

  logic [DW-1:0] dvd_q [3];
  logic [DW-1:0] dvd_d [3];
  logic [RW-1:0] rem_q [3];
  logic [RW-1:0] rem_d [3];
  logic [RW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // Two restoring steps per lane per cycle; quotient bits shift in from the bottom
  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] rem;
    logic [DW-1:0] dvd;
    t   = '0;
    rem = '0;
    dvd = '0;
    for (int l = 0; l < 3; l++) begin
      rem = rem_q[l];
      dvd = dvd_q[l];
      for (int s = 0; s < cdma_pkg::DIV_RADIX_BITS; s++) begin
        t   = {rem, dvd[DW-1]};
        dvd = {dvd[DW-2:0], 1'b0};
        if (t >= {1'b0, div_q}) begin
          rem    = RW'(t - {1'b0, div_q});
          dvd[0] = 1'b1;
        end else begin
          rem = t[RW-1:0];
        end
      end
      rem_d[l] = rem;
      dvd_d[l] = dvd;
    end
  end

  // Lane registers: load on start, advance while busy, hold the quotient after
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q[0] <= dividend_i.total;
      dvd_q[1] <= dividend_i.rd;
      dvd_q[2] <= dividend_i.wr;
      for (int l = 0; l < 3; l++) begin
        rem_q[l] <= '0;
      end
      div_q <= divisor_i;
    end else if (busy_q) begin
      for (int l = 0; l < 3; l++) begin
        dvd_q[l] <= dvd_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(cdma_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quot_o.total = dvd_q[0];
  assign quot_o.rd    = dvd_q[1];
  assign quot_o.wr    = dvd_q[2];

endmodule

>>> hdl/counter_delta_moving_average_unit.sv
// Counter delta moving average unit: top level with the window walk sequencer.
// Each input beat carries absolute read and write sector counters; the unit turns them into
// halved deltas (kilobytes), rebasing to zero delta whenever a counter steps backwards or on
// the first beat after reset, and returns one beat with the Q8 truncated averages of the
// newest n slots of the read, write and total histories, n being window_length clamped to
// 1..HISTORY_DEPTH, and never above WIN_MAX (31). One beat is handled at a time: the gap from
// one acceptance to the earliest next one is set by the walk over the history memory (one
// slot read and shifted per cycle) and by the shared divider, which resolves two quotient
// bits per cycle. A finished result sits in the output register, so the next beat can be
// accepted while it waits; the unit only stalls when a new result is ready and the previous
// one has still not been taken. window_length should only be written while the unit is idle.
module counter_delta_moving_average_unit #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: window_length
  input  logic                        cfg_we_i,
  input  logic [cdma_pkg::WIN_W-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [31:0] read_sectors, [63:32] write_sectors
  input  logic [63:0]                 s_axis_tdata_i,
  // Output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [39:0] avg_total_q8, [78:40] avg_read_q8, [117:79] avg_write_q8, [119:118] zero
  output logic [119:0]                m_axis_tdata_o
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned WW = cdma_pkg::WIN_W;
  localparam int unsigned DEPTH_CAP =
    (HISTORY_DEPTH > cdma_pkg::WIN_MAX) ? cdma_pkg::WIN_MAX : HISTORY_DEPTH;
  localparam logic [WW-1:0] DEPTH_N = WW'(DEPTH_CAP);
  localparam int unsigned CW = cdma_pkg::CNT_W;
  localparam int unsigned SW = cdma_pkg::SUM_W;
  localparam int unsigned DW = cdma_pkg::DVD_W;
  localparam int unsigned FW = cdma_pkg::FRAC_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WR1   = 3'd3;
  localparam logic [2:0] ST_WR0   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [WW-1:0]  win_q;
  logic [WW-1:0]  n_eff;
  logic [WW-1:0]  n_q;
  logic [WW-1:0]  idx_q, idx_d;
  logic [WW-1:0]  rd_slot_q;
  logic [WW-1:0]  wb_slot;
  logic           rd_pend_q;
  logic [CW-1:0]  prev_rd_q, prev_wr_q;
  logic [CW-1:0]  in_rd, in_wr;
  logic           rebase;
  logic [CW-1:0]  diff_rd, diff_wr;
  cdma_pkg::hist_entry_t new_q, new_d;
  logic [SW-1:0]  sum_rd_q, sum_wr_q;
  logic [SW:0]    sum_tot;
  logic           in_acc;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  cdma_pkg::hist_entry_t ram_wdata, ram_rdata;

  logic                 div_start, div_done;
  cdma_pkg::div_lanes_t div_dvd, div_quot;

  logic                 out_vld_q;
  logic [119:0]         out_data_q;
  logic                 out_free;

  assign in_rd  = s_axis_tdata_i[31:0];
  assign in_wr  = s_axis_tdata_i[63:32];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Clamp window to 1..depth
  always_comb begin
    if (win_q == '0) begin
      n_eff = WW'(1);
    end else if (win_q > DEPTH_N) begin
      n_eff = DEPTH_N;
    end else begin
      n_eff = win_q;
    end
  end

  // Halved deltas, zero when a counter stepped backwards
  assign rebase  = (in_rd < prev_rd_q) || (in_wr < prev_wr_q);
  assign diff_rd = rebase ? '0 : (in_rd - prev_rd_q);
  assign diff_wr = rebase ? '0 : (in_wr - prev_wr_q);
  assign new_d.rd = diff_rd[CW-1:1];
  assign new_d.wr = diff_wr[CW-1:1];

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WW'(2);
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Sequencer next state and read pointer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d   = n_eff - WW'(1);
          state_d = (n_eff == WW'(1)) ? ST_WR0 : ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx_q == WW'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q - WW'(1);
        end
      end
      ST_DRAIN: state_d = ST_WR1;
      ST_WR1:   state_d = ST_WR0;
      ST_WR0:   state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory ports: read slots n-1 down to 1, write slots n-2..1 one slot up, then slots 1 and 0
  assign wb_slot = rd_slot_q + WW'(1);
  always_comb begin
    ram_re    = (state_q == ST_WALK);
    ram_raddr = AW'(idx_q);
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_q;
    if (rd_pend_q) begin
      ram_we    = (rd_slot_q != n_q - WW'(1));
      ram_waddr = AW'(wb_slot);
      ram_wdata = ram_rdata;
    end else if (state_q == ST_WR1) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(1);
    end else if (state_q == ST_WR0) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      n_q       <= WW'(1);
      rd_pend_q <= 1'b0;
      rd_slot_q <= '0;
      prev_rd_q <= '1;
      prev_wr_q <= '1;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_pend_q <= ram_re;
      if (ram_re) begin
        rd_slot_q <= idx_q;
      end
      if (in_acc) begin
        n_q       <= n_eff;
        prev_rd_q <= in_rd;
        prev_wr_q <= in_wr;
      end
    end
  end

  // Newest slot and running window sums
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_q    <= new_d;
      sum_rd_q <= SW'(new_d.rd);
      sum_wr_q <= SW'(new_d.wr);
    end else if (rd_pend_q) begin
      sum_rd_q <= sum_rd_q + SW'(ram_rdata.rd);
      sum_wr_q <= sum_wr_q + SW'(ram_rdata.wr);
    end
  end

  // Scale sums to Q8 and divide by the window
  assign sum_tot        = {1'b0, sum_rd_q} + {1'b0, sum_wr_q};
  assign div_start      = (state_q == ST_WR0);
  assign div_dvd.total  = DW'({sum_tot, FW'(0)});
  assign div_dvd.rd     = DW'({sum_rd_q, FW'(0)});
  assign div_dvd.wr     = DW'({sum_wr_q, FW'(0)});

  cdma_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cdma_div3 u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (n_q),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Output register
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_data_q <= {2'b00,
                     div_quot.wr[cdma_pkg::AVG_DIR_W-1:0],
                     div_quot.rd[cdma_pkg::AVG_DIR_W-1:0],
                     div_quot.total[cdma_pkg::AVG_TOTAL_W-1:0]};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> tb/counter_delta_moving_average_unit_tb.sv
// Self-checking testbench for the counter delta moving average unit.
`timescale 1ns / 1ps

module counter_delta_moving_average_unit_tb;

  localparam int unsigned HIST_DEPTH = 16;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [cdma_pkg::AVG_DIR_W-1:0]   wr;
    logic [cdma_pkg::AVG_DIR_W-1:0]   rd;
    logic [cdma_pkg::AVG_TOTAL_W-1:0] total;
  } avg_beat_t;

  // Track counter deltas and windowed averages; hold the averages still owed by the unit.
  class delta_avg_tracker;
    logic [cdma_pkg::WIN_W-1:0]   window;
    logic [cdma_pkg::CNT_W-1:0]   prev_rd;
    logic [cdma_pkg::CNT_W-1:0]   prev_wr;
    logic [cdma_pkg::DELTA_W-1:0] rd_hist [HIST_DEPTH];
    logic [cdma_pkg::DELTA_W-1:0] wr_hist [HIST_DEPTH];
    logic [cdma_pkg::CNT_W-1:0]   tot_hist[HIST_DEPTH];
    avg_beat_t                    owed_avg_q[$];
    int unsigned                  errors;

    function new();
      window  = 5'd2;
      prev_rd = '1;
      prev_wr = '1;
      foreach (rd_hist[i]) begin
        rd_hist[i]  = '0;
        wr_hist[i]  = '0;
        tot_hist[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_window(logic [cdma_pkg::WIN_W-1:0] w);
      window = w;
    endfunction

    function int unsigned pending();
      return owed_avg_q.size();
    endfunction

    // Work out the averages caused by one accepted counter pair.
    function void note_counters(logic [cdma_pkg::CNT_W-1:0] rd, logic [cdma_pkg::CNT_W-1:0] wr);
      int unsigned n;
      int          i;
      logic [63:0] sum_t;
      logic [63:0] sum_r;
      logic [63:0] sum_w;
      logic [63:0] q_t;
      logic [63:0] q_r;
      logic [63:0] q_w;
      avg_beat_t   avg;
      n = (window == 0) ? 1 : ((window > HIST_DEPTH) ? HIST_DEPTH : window);
      // Rebase when either counter stepped backwards
      if (rd < prev_rd || wr < prev_wr) begin
        prev_rd = rd;
        prev_wr = wr;
      end
      rd_hist[0]  = cdma_pkg::DELTA_W'((rd - prev_rd) >> 1);
      wr_hist[0]  = cdma_pkg::DELTA_W'((wr - prev_wr) >> 1);
      tot_hist[0] = {1'b0, rd_hist[0]} + {1'b0, wr_hist[0]};
      sum_t = '0;
      sum_r = '0;
      sum_w = '0;
      for (i = 0; i < int'(n); i++) begin
        sum_t += tot_hist[i];
        sum_r += rd_hist[i];
        sum_w += wr_hist[i];
      end
      q_t = (sum_t << 8) / n;
      q_r = (sum_r << 8) / n;
      q_w = (sum_w << 8) / n;
      avg.total = q_t[cdma_pkg::AVG_TOTAL_W-1:0];
      avg.rd    = q_r[cdma_pkg::AVG_DIR_W-1:0];
      avg.wr    = q_w[cdma_pkg::AVG_DIR_W-1:0];
      owed_avg_q.push_back(avg);
      // Shift only the slots inside the window
      for (i = int'(n) - 1; i > 0; i--) begin
        tot_hist[i] = tot_hist[i-1];
        rd_hist[i]  = rd_hist[i-1];
        wr_hist[i]  = wr_hist[i-1];
      end
      prev_rd = rd;
      prev_wr = wr;
    endfunction

    // Compare one output beat with the oldest owed averages.
    function void check_averages(logic [119:0] data);
      avg_beat_t got;
      avg_beat_t want;
      got = data[117:0];
      if (owed_avg_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] unexpected output beat %h", $realtime, data);
        return;
      end
      want = owed_avg_q.pop_front();
      if (got.total !== want.total || got.rd !== want.rd || got.wr !== want.wr) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] avg mismatch: total exp %h got %h, rd exp %h got %h, wr exp %h got %h",
                   $realtime, want.total, got.total, want.rd, got.rd, want.wr, got.wr);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cdma_pkg::WIN_W-1:0]     cfg_wdata_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [63:0]                    s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [119:0]                   m_axis_tdata_o;

  delta_avg_tracker               tracker;
  bit                             tx_gaps;
  bit                             rx_stalls;
  logic [cdma_pkg::CNT_W-1:0]     cur_rd;
  logic [cdma_pkg::CNT_W-1:0]     cur_wr;

  counter_delta_moving_average_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one counter pair and hold it until the unit takes the beat.
  task automatic send_counters(input logic [cdma_pkg::CNT_W-1:0] rd,
                               input logic [cdma_pkg::CNT_W-1:0] wr);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {wr, rd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_counters(rd, wr);
    cur_rd = rd;
    cur_wr = wr;
  endtask

  // Drop valid, drain all owed beats, then write the window register.
  task automatic write_window(input logic [cdma_pkg::WIN_W-1:0] w);
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_window(w);
  endtask

  // Mostly growing counters with random steps, some backward jumps and noise.
  task automatic send_random_polls(input int unsigned count);
    logic [cdma_pkg::CNT_W-1:0] rd;
    logic [cdma_pkg::CNT_W-1:0] wr;
    logic [cdma_pkg::CNT_W-1:0] step_rd;
    logic [cdma_pkg::CNT_W-1:0] step_wr;
    repeat (count) begin
      case ($urandom_range(0, 19))
        0: begin
          rd = $urandom();
          wr = $urandom();
        end
        1: begin
          rd = $urandom_range(0, cur_rd);
          wr = cur_wr + $urandom_range(0, 4096);
        end
        2: begin
          rd = cur_rd + $urandom_range(0, 4096);
          wr = $urandom_range(0, cur_wr);
        end
        3: begin
          rd = '1;
          wr = '1;
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       begin step_rd = $urandom_range(0, 64);   step_wr = $urandom_range(0, 64); end
            1:       begin step_rd = $urandom() & 32'hF_FFFF; step_wr = $urandom() & 32'hF_FFFF; end
            default: begin step_rd = $urandom();              step_wr = $urandom(); end
          endcase
          rd = cur_rd + step_rd;
          wr = cur_wr + step_wr;
        end
      endcase
      send_counters(rd, wr);
    end
  endtask

  // Accept output beats and stall the receiver in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_averages(m_axis_tdata_o);
      if (stall_left > 0)
        stall_left--;
      else if (rx_stalls && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      m_axis_tready_i <= (stall_left == 0);
    end
  end

  // Main sequence: reset, directed polls, then random phases over several windows.
  initial begin
    logic [cdma_pkg::WIN_W-1:0] phase_win[10];
    phase_win = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd8, 5'd15, 5'd3};
    tracker   = new();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    cur_rd    = '0;
    cur_wr    = '0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First poll at all ones: zero delta against the reset previous pair
    send_counters('1, '1);
    // Both backward, then the largest possible delta
    send_counters('0, '0);
    send_counters('1, '1);
    send_counters('1, '1);
    // One counter backward at a time
    send_counters('0, '1);
    send_counters(32'd1, '1);
    send_counters(32'd3, '1);
    send_counters(32'd3, '0);
    send_counters(32'd5, 32'd7);
    send_counters(32'h8000_0005, 32'h8000_0007);
    send_counters(32'h8000_0004, 32'hFFFF_FFFE);
    send_counters(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Widest window: alternate rebase and maximum delta
    write_window(5'd16);
    repeat (4) begin
      send_counters('0, '0);
      send_counters('1, '1);
    end
    send_counters(32'h5555_5555, 32'hAAAA_AAAA);
    send_counters(32'hAAAA_AAAA, 32'hAAAA_AAAA);

    // Random phases; one quiet stretch in the middle and a quiet final phase
    foreach (phase_win[p]) begin
      write_window(phase_win[p]);
      tx_gaps   = (p != 3) && (p != 9);
      rx_stalls = (p != 3) && (p != 9);
      send_random_polls(100);
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain the tail, then settle
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hdl/cdma_pkg.sv
hdl/cdma_hist_ram.sv
hdl/cdma_div3.sv
hdl/counter_delta_moving_average_unit.sv
tb/counter_delta_moving_average_unit_tb.sv
